[hdl/dfd_pkg.sv]
// shared constants, state type and divider control and status structs for the double fraction to decimal unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfd_pkg;

  localparam int FRAC_BITS  = 52;
  localparam int EXP_W      = 12;
  localparam int DATA_W     = 64;
  localparam int PLACE_W    = 7;
  localparam int COUNT_W    = 5;
  localparam int CHUNK_W    = 16;
  localparam int DIV_SHIFT  = 24;

  localparam logic [EXP_W-1:0]   EXP_BIAS   = 12'd1023;
  localparam logic [DATA_W-1:0]  SCALE_LIMIT = 64'h1999_9999_9999_9999;
  localparam logic [DATA_W-1:0]  BIG_LIMIT  = 64'h8AC7_2304_89E8_0000;
  localparam logic [20:0]        DIV_RECIP  = 21'd1677722;
  localparam logic [1:0]         BIG_PASSES = 2'd3;
  localparam logic [PLACE_W-1:0] COUNT_MAX  = 7'd31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_BIG_GO,
    S_BIG_WAIT,
    S_TRIM_GO,
    S_TRIM_WAIT,
    S_DONE
  } dfd_state_t;

  typedef struct packed {
    logic start;
  } dfd_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } dfd_div_stat_t;

endpackage

`default_nettype wire

[hdl/dfd_scale.sv]
// one step of the fraction bit walk: scale by ten or halve the weight, then add
// depends on dfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfd_scale (
  input  wire logic [dfd_pkg::DATA_W-1:0] value,
  input  wire logic [dfd_pkg::DATA_W-1:0] weight,
  input  wire logic                       frac_bit,
  output logic      [dfd_pkg::DATA_W-1:0] value_next,
  output logic      [dfd_pkg::DATA_W-1:0] weight_next,
  output logic                            scaled
);
  import dfd_pkg::*;

  logic [DATA_W-1:0] value_x10;
  logic [DATA_W-1:0] weight_x5;

  always_comb begin
    value_x10 = (value << 3) + (value << 1);
    weight_x5 = (weight << 2) + weight;
    scaled    = (value <= SCALE_LIMIT);
    if (scaled) begin
      weight_next = weight_x5;
      value_next  = value_x10 + (frac_bit ? weight_x5 : '0);
    end else begin
      weight_next = weight >> 1;
      value_next  = value + (frac_bit ? (weight >> 1) : '0);
    end
  end

endmodule

`default_nettype wire

[hdl/dfd_div10.sv]
// shared divide by ten unit, 16 bits of dividend per cycle, msb first
// depends on dfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfd_div10 (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dfd_pkg::dfd_div_ctrl_t     ctrl,
  input  wire logic [dfd_pkg::DATA_W-1:0] dividend,
  output dfd_pkg::dfd_div_stat_t          stat,
  output logic      [dfd_pkg::DATA_W-1:0] quotient
);
  import dfd_pkg::*;

  logic                  busy;
  logic                  done;
  logic [1:0]            cnt;
  logic [3:0]            rem;
  logic [DATA_W-1:0]     sh;
  logic [19:0]           x;
  logic [40:0]           prod;
  logic [CHUNK_W-1:0]    q;
  logic [19:0]           r_full;

  // reciprocal multiply, exact for x below 10 * 2^16
  always_comb begin
    x      = {rem, sh[DATA_W-1 -: CHUNK_W]};
    prod   = 41'(x) * 41'(DIV_RECIP);
    q      = prod[DIV_SHIFT +: CHUNK_W];
    r_full = x - ((20'(q) << 3) + (20'(q) << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[DATA_W-CHUNK_W-1:0], q};
      rem <= r_full[3:0];
    end
  end

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.rem_zero = (rem == 4'd0);
  assign quotient      = sh;

endmodule

`default_nettype wire

[hdl/double_fraction_to_decimal_unit.sv]
// top level: sequencer for the fraction bit walk, decimal truncation and trailing zero strip
// depends on dfd_pkg, dfd_scale, dfd_div10
// steps: walk the fraction bits (up to 52), divide by ten four times when the value
// exceeds 10^19, then once per trailing zero and once for the last check (none for a zero value)
// one item at a time, paced by the walk and the shared divide by ten unit
// reset: sync, clears state
`timescale 1ns / 1ps
`default_nettype none

module double_fraction_to_decimal_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [63:0]                   double_bits,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               is_zero,
  output logic                               sign_negative,
  output logic signed [dfd_pkg::EXP_W-1:0]   exponent,
  output logic      [dfd_pkg::DATA_W-1:0]    frac_digits,
  output logic      [dfd_pkg::COUNT_W-1:0]   digit_count
);
  import dfd_pkg::*;

  dfd_state_t state, state_next;

  logic                       in_xfer;
  logic                       out_free;
  logic [FRAC_BITS-1:0]       fr;
  logic [DATA_W-1:0]          value;
  logic [DATA_W-1:0]          weight;
  logic signed [PLACE_W-1:0]  places;
  logic [1:0]                 big_cnt;
  logic                       zero_r;
  logic                       sign_r;
  logic [EXP_W-1:0]           exp_r;

  logic [DATA_W-1:0]          step_value;
  logic [DATA_W-1:0]          step_weight;
  logic                       step_scaled;

  dfd_div_ctrl_t              div_ctrl;
  dfd_div_stat_t              div_stat;
  logic [DATA_W-1:0]          div_quot;

  logic [COUNT_W-1:0]         count_final;

  dfd_scale u_scale (
    .value       (value),
    .weight      (weight),
    .frac_bit    (fr[FRAC_BITS-1]),
    .value_next  (step_value),
    .weight_next (step_weight),
    .scaled      (step_scaled)
  );

  dfd_div10 u_div10 (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (value),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if ((value == '0) || (places < 0)) begin
      count_final = '0;
    end else if (places > $signed(COUNT_MAX)) begin
      count_final = COUNT_MAX[COUNT_W-1:0];
    end else begin
      count_final = places[COUNT_W-1:0];
    end
  end

  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (fr == '0) begin
          state_next = (value > BIG_LIMIT) ? S_BIG_GO : S_TRIM_GO;
        end
      end
      S_BIG_GO: begin
        div_ctrl.start = 1'b1;
        state_next     = S_BIG_WAIT;
      end
      S_BIG_WAIT: begin
        if (div_stat.done) begin
          state_next = (big_cnt == BIG_PASSES) ? S_TRIM_GO : S_BIG_GO;
        end
      end
      S_TRIM_GO: begin
        if (value == '0) begin
          state_next = S_DONE;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = S_TRIM_WAIT;
        end
      end
      S_TRIM_WAIT: begin
        if (div_stat.done) begin
          state_next = div_stat.rem_zero ? S_TRIM_GO : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          fr      <= double_bits[FRAC_BITS-1:0];
          value   <= '0;
          weight  <= 64'd1;
          places  <= '0;
          big_cnt <= '0;
          zero_r  <= (double_bits[62:0] == 63'd0);
          sign_r  <= double_bits[63];
          exp_r   <= {1'b0, double_bits[62:52]} - EXP_BIAS;
        end
      end
      S_WALK: begin
        if (fr != '0) begin
          value  <= step_value;
          weight <= step_weight;
          fr     <= fr << 1;
          if (step_scaled) begin
            places <= places + 7'sd1;
          end
        end
      end
      S_BIG_WAIT: begin
        if (div_stat.done) begin
          value   <= div_quot;
          places  <= places - 7'sd1;
          big_cnt <= big_cnt + 2'd1;
        end
      end
      S_TRIM_WAIT: begin
        if (div_stat.done && div_stat.rem_zero) begin
          value  <= div_quot;
          places <= places - 7'sd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      is_zero       <= zero_r;
      sign_negative <= sign_r;
      exponent      <= exp_r;
      frac_digits   <= value;
      digit_count   <= count_final;
    end
  end

endmodule

`default_nettype wire

[sim/double_fraction_to_decimal_unit_test.sv]
// self-checking testbench for double_fraction_to_decimal_unit: directed corner doubles, then
// random bursts, each result checked against a behavioural fraction to decimal predictor
// depends on dfd_pkg and the double_fraction_to_decimal_unit rtl
`timescale 1ns / 1ps

module double_fraction_to_decimal_unit_test;

  localparam int          ITEM_TOTAL    = 1750;
  localparam int          CYCLE_LIMIT   = 3_000_000;
  localparam int          TAIL_CYCLES   = 250;
  localparam int          FRACTION_W    = 52;
  localparam int          PLACES_CAP    = 31;
  localparam logic [63:0] SCALE_BOUND   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
  localparam logic [63:0] TRUNC_BOUND   = 64'd10000000000000000000;
  localparam logic [63:0] TRUNC_DIVISOR = 64'd10000;
  localparam logic [63:0] DECIMAL_BASE  = 64'd10;
  localparam logic [11:0] EXP_OFFSET    = 12'd1023;

  typedef struct packed {
    logic                           is_zero;
    logic                           sign_negative;
    logic [dfd_pkg::EXP_W-1:0]      exponent;
    logic [dfd_pkg::DATA_W-1:0]     frac_digits;
    logic [dfd_pkg::COUNT_W-1:0]    digit_count;
  } decimal_split_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  class fraction_scoreboard;
    decimal_split_t pending[$];
    int             error_count;

    function new();
      error_count = 0;
    endfunction

    function decimal_split_t predict_split(logic [63:0] bits);
      decimal_split_t split;
      logic [63:0]    value;
      logic [63:0]    weight;
      logic [63:0]    below;
      int             places;
      int             pos;
      bit             walking;
      value   = '0;
      weight  = 64'd1;
      places  = 0;
      walking = 1'b1;
      // walk fraction bits from the top while any set bit remains at or below
      for (pos = FRACTION_W - 1; pos >= 0 && walking; pos--) begin
        below = 64'd1 << pos;
        if ((bits & (below | (below - 64'd1))) == 64'd0) begin
          walking = 1'b0;
        end else begin
          if (value <= SCALE_BOUND) begin
            value  = value * DECIMAL_BASE;
            weight = weight * 64'd5;
            places++;
          end else begin
            weight = weight >> 1;
          end
          if ((bits & below) != 64'd0) value = value + weight;
        end
      end
      if (value > TRUNC_BOUND) begin
        value  = value / TRUNC_DIVISOR;
        places = places - 4;
      end
      while (value != 64'd0 && (value % DECIMAL_BASE) == 64'd0) begin
        value = value / DECIMAL_BASE;
        places--;
      end
      if (value == 64'd0 || places < 0) places = 0;
      if (places > PLACES_CAP) places = PLACES_CAP;
      split.is_zero       = (bits[62:0] == 63'd0);
      split.sign_negative = bits[63];
      split.exponent      = {1'b0, bits[62:52]} - EXP_OFFSET;
      if (bits[51:0] != 52'd0) begin
        split.frac_digits = value;
        split.digit_count = places[dfd_pkg::COUNT_W-1:0];
      end else begin
        split.frac_digits = '0;
        split.digit_count = '0;
      end
      return split;
    endfunction

    function void note_transfer(logic [63:0] bits);
      pending.push_back(predict_split(bits));
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
        error_count++;
      end
    endfunction

    function void check_transfer(decimal_split_t got);
      decimal_split_t want;
      if (pending.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %0h", $time, got);
        error_count++;
      end else begin
        want = pending.pop_front();
        compare_field("is_zero", want.is_zero, got.is_zero);
        compare_field("sign_negative", want.sign_negative, got.sign_negative);
        compare_field("exponent", want.exponent, got.exponent);
        compare_field("frac_digits", want.frac_digits, got.frac_digits);
        compare_field("digit_count", want.digit_count, got.digit_count);
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [63:0]                         double_bits;
  logic                                out_valid;
  logic                                out_stall;
  logic                                is_zero;
  logic                                sign_negative;
  logic signed [dfd_pkg::EXP_W-1:0]    exponent;
  logic [dfd_pkg::DATA_W-1:0]          frac_digits;
  logic [dfd_pkg::COUNT_W-1:0]         digit_count;

  fraction_scoreboard split_board;
  int                 burst_left;

  double_fraction_to_decimal_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .double_bits   (double_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_zero       (is_zero),
    .sign_negative (sign_negative),
    .exponent      (exponent),
    .frac_digits   (frac_digits),
    .digit_count   (digit_count)
  );

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] random_double();
    logic [63:0] bits;
    logic [51:0] frac;
    int          sel;
    int          keep;
    bits = {$urandom, $urandom};
    sel  = $urandom_range(0, 19);
    keep = (sel < 15) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    if (sel >= 6 && sel <= 14) begin
      // short fractions, as most everyday doubles have
      if (sel >= 12) keep = $urandom_range(13, 40);
      bits[51:0] = bits[51:0] & ~({52{1'b1}} >> keep);
    end else if (sel == 15 || sel == 16) begin
      frac = '0;
      repeat ($urandom_range(1, 3)) frac[$urandom_range(0, 51)] = 1'b1;
      bits[51:0] = frac;
    end else if (sel == 17 || sel == 18) begin
      case ($urandom_range(0, 5))
        0:       bits[62:52] = 11'h000;
        1:       bits[62:52] = 11'h7FF;
        2:       bits[62:52] = 11'd1023;
        3:       bits[62:52] = 11'd1022;
        4:       bits[62:52] = 11'd1024;
        default: bits[62:52] = 11'h001;
      endcase
      if ($urandom_range(0, 1) == 0) bits[51:0] = bits[51:0] & ~({52{1'b1}} >> keep);
    end else if (sel == 19) begin
      bits[51:0] = '0;
    end
    return bits;
  endfunction

  task automatic send_double(input logic [63:0] bits);
    @(negedge clk);
    in_valid    <= 1'b1;
    double_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_board.note_transfer(bits);
  endtask

  task automatic send_paced(input logic [63:0] bits);
    int gap;
    send_double(bits);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(1, 4);
        8:             gap = $urandom_range(5, 30);
        default:       gap = $urandom_range(40, 150);
      endcase
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin : result_stall
    stall_mode_t mode;
    int          span;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      span = $urandom_range(1, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 1) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      split_board.check_transfer({is_zero, sign_negative, exponent, frac_digits, digit_count});
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] corner_cases [0:22];
    int          i;
    split_board = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    double_bits = '0;
    burst_left  = 0;
    corner_cases = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
      64'h3FF8_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'hBFD0_0000_0000_0000,
      64'h3FB9_9999_9999_999A, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
      64'h7FF8_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001,
      64'h3FF0_0000_0000_8000, 64'h3FF0_0000_0400_0000, 64'h4009_21FB_5444_2D18,
      64'h3FF4_0000_0000_0000, 64'h3FF0_0800_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
      64'h0010_0000_0000_0000, 64'hC00A_AAAA_AAAA_AAAB
    };
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    for (i = 0; i < 23; i++) send_paced(corner_cases[i]);
    repeat (ITEM_TOTAL) send_paced(random_double());
    @(negedge clk) in_valid <= 1'b0;
    // drain, then give a stray transfer time to show up
    while (split_board.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (split_board.error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
